// File: rtl/imu_uart_frame_parser_defines.svh
// Assertion macros shared by the frame parser modules.
// Both expect signals named clk and rst in the module that uses them.
`ifndef IMU_UART_FRAME_PARSER_DEFINES_SVH
`define IMU_UART_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, off during reset
`define IUFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iufp: same-cycle check failed");

// Next-cycle implication, off during reset
`define IUFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iufp: next-cycle check failed");

`endif

// File: rtl/iufp_pkg.sv
`default_nettype none

package iufp_pkg;

  // Frame marker bytes
  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  // Result field widths
  localparam int RATE_W  = 20;
  localparam int ANGLE_W = 17;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TYPE   = 2'd1,
    PH_DATA   = 2'd2,
    PH_CHECK  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_GYRO   = 2'd0,
    KIND_ANGLE  = 2'd1,
    KIND_ACCEL  = 2'd2,
    KIND_BADSUM = 2'd3
  } kind_t;

  // Frame event from the parser to the hold stage
  typedef struct packed {
    logic         valid;
    kind_t        kind;
    logic [15:0]  roll_raw;
    logic [15:0]  pitch_raw;
    logic [15:0]  yaw_raw;
    logic [15:0]  rate_raw;
  } evt_t;

endpackage

`default_nettype wire

// File: rtl/iufp_fsm.sv
`default_nettype none

`include "imu_uart_frame_parser_defines.svh"

module iufp_fsm #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    rx_q,
  output iufp_pkg::evt_t evt
);
  import iufp_pkg::*;

  localparam int CNT_W = $clog2(PAYLOAD_BYTES);

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       kind_byte, kind_byte_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       payload [PAYLOAD_BYTES];

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      byte_count  <= '0;
      kind_byte   <= '0;
      running_sum <= '0;
    end else if (step) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      kind_byte   <= kind_byte_next;
      running_sum <= running_sum_next;
    end
  end

  // Data bytes, only read after being written in the same frame
  always_ff @(posedge clk) begin
    if (step && phase == PH_DATA) begin
      payload[byte_count] <= rx_q;
    end
  end

  // Next state and frame event
  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    kind_byte_next   = kind_byte;
    running_sum_next = running_sum;
    evt.valid        = 1'b0;
    evt.kind         = KIND_ACCEL;
    // Little-endian words from the data bytes
    evt.roll_raw     = {payload[1], payload[0]};
    evt.pitch_raw    = {payload[3], payload[2]};
    evt.yaw_raw      = {payload[5], payload[4]};
    evt.rate_raw     = {payload[5], payload[4]};
    unique case (phase)
      PH_HEADER: begin
        if (rx_q == HDR_BYTE) begin
          running_sum_next = rx_q;
          phase_next       = PH_TYPE;
        end
      end
      PH_TYPE: begin
        kind_byte_next   = rx_q;
        running_sum_next = running_sum + rx_q;
        if (rx_q == TYPE_ACCEL || rx_q == TYPE_GYRO || rx_q == TYPE_ANGLE) begin
          byte_count_next = '0;
          phase_next      = PH_DATA;
        end else begin
          phase_next = PH_HEADER;
        end
      end
      PH_DATA: begin
        running_sum_next = running_sum + rx_q;
        byte_count_next  = byte_count + 1'b1;
        if (byte_count == CNT_W'(PAYLOAD_BYTES - 1)) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_next = PH_HEADER;
        evt.valid  = 1'b1;
        if (running_sum != rx_q) begin
          evt.kind = KIND_BADSUM;
        end else if (kind_byte == TYPE_GYRO) begin
          evt.kind = KIND_GYRO;
        end else if (kind_byte == TYPE_ANGLE) begin
          evt.kind = KIND_ANGLE;
        end else begin
          evt.kind = KIND_ACCEL;
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  // Counter stays inside the data field
  `IUFP_ASSERT_IMP(a_count_range, phase == PH_DATA,
                   byte_count <= CNT_W'(PAYLOAD_BYTES - 1))
  // A result only comes out of the checksum phase
  `IUFP_ASSERT_IMP(a_evt_phase, evt.valid, phase == PH_CHECK)

endmodule

`default_nettype wire

// File: rtl/iufp_hold.sv
`default_nettype none

`include "imu_uart_frame_parser_defines.svh"

module iufp_hold (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  iufp_pkg::evt_t                     evt,
  input  logic                               result_stall,
  output logic                               result_valid,
  output logic [1:0]                         frame_kind,
  output logic signed [iufp_pkg::RATE_W-1:0]  rate_z_q8,
  output logic signed [iufp_pkg::ANGLE_W-1:0] roll_q8,
  output logic signed [iufp_pkg::ANGLE_W-1:0] pitch_q8,
  output logic signed [iufp_pkg::ANGLE_W-1:0] yaw_q8,
  output logic                               rate_ready
);
  import iufp_pkg::*;

  logic                      load;
  kind_t                     kind;
  logic signed [23:0]        rate_prod;
  logic signed [21:0]        roll_prod, pitch_prod, yaw_prod;
  logic signed [RATE_W-1:0]  held_rate;
  logic signed [ANGLE_W-1:0] held_roll, held_pitch, held_yaw;
  logic                      ready_flag;

  assign load = step && evt.valid;

  // Constant scaling: rate = floor(raw*125/8), angle = floor(raw*45/32)
  assign rate_prod  = 24'(signed'(evt.rate_raw)) * 24'sd125;
  assign roll_prod  = 22'(signed'(evt.roll_raw)) * 22'sd45;
  assign pitch_prod = 22'(signed'(evt.pitch_raw)) * 22'sd45;
  assign yaw_prod   = 22'(signed'(evt.yaw_raw)) * 22'sd45;

  // Result register: kind plus held values
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      kind         <= KIND_GYRO;
      held_rate    <= '0;
      held_roll    <= '0;
      held_pitch   <= '0;
      held_yaw     <= '0;
      ready_flag   <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
      kind         <= evt.kind;
      if (evt.kind == KIND_GYRO) begin
        held_rate  <= rate_prod[22:3];
        ready_flag <= 1'b1;
      end
      if (evt.kind == KIND_ANGLE) begin
        held_roll  <= roll_prod[21:5];
        held_pitch <= pitch_prod[21:5];
        held_yaw   <= yaw_prod[21:5];
      end
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  assign frame_kind = kind;
  assign rate_z_q8  = held_rate;
  assign roll_q8    = held_roll;
  assign pitch_q8   = held_pitch;
  assign yaw_q8     = held_yaw;
  assign rate_ready = ready_flag;

  // Never overwrite a result still waiting downstream
  `IUFP_ASSERT_IMP(a_no_overwrite, load, !(result_valid && result_stall))
  // Ready flag is sticky
  `IUFP_ASSERT_NEXT(a_ready_sticky, ready_flag, ready_flag)
  // A gyro result always carries the ready flag
  `IUFP_ASSERT_IMP(a_gyro_ready, result_valid && kind == KIND_GYRO, ready_flag)
  // Angles move only with an angle result
  `IUFP_ASSERT_NEXT(a_angle_move, !load || evt.kind != KIND_ANGLE,
                    $stable(held_roll) && $stable(held_yaw))

endmodule

`default_nettype wire

// File: rtl/imu_uart_frame_parser.sv
// Serial IMU frame parser. Takes one received byte per request on the byte
// channel and hunts for 11-byte frames (0x55, type, data bytes, 8-bit sum).
// Every checksum byte yields one result request carrying the frame kind and
// the held Z rate (deg/s) and roll/pitch/yaw (deg), all signed Q8, floored.
// A byte is taken every clock cycle unless the channel stalls; the byte
// path is an input register, the parser and constant scaling, then the
// result register. The byte channel stalls only when a checksum byte must
// load the result register while the previous result is still stalled;
// header, type and data bytes keep flowing.
`default_nettype none

module imu_uart_frame_parser #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               byte_valid,
  output logic                               byte_stall,
  input  logic [7:0]                         rx_byte,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [1:0]                         frame_kind,
  output logic signed [iufp_pkg::RATE_W-1:0]  rate_z_q8,
  output logic signed [iufp_pkg::ANGLE_W-1:0] roll_q8,
  output logic signed [iufp_pkg::ANGLE_W-1:0] pitch_q8,
  output logic signed [iufp_pkg::ANGLE_W-1:0] yaw_q8,
  output logic                               rate_ready
);
  import iufp_pkg::*;

  logic       in_full;
  logic [7:0] rx_q;
  logic       advance;
  logic       step;
  evt_t       evt;

  // Input byte moves on unless it needs an occupied result register
  assign advance    = !evt.valid || !result_valid || !result_stall;
  assign step       = in_full && advance;
  assign byte_stall = in_full && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      rx_q <= rx_byte;
    end
  end

  iufp_fsm #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .rx_q (rx_q),
    .evt  (evt)
  );

  iufp_hold u_hold (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .evt          (evt),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .frame_kind   (frame_kind),
    .rate_z_q8    (rate_z_q8),
    .roll_q8      (roll_q8),
    .pitch_q8     (pitch_q8),
    .yaw_q8       (yaw_q8),
    .rate_ready   (rate_ready)
  );

endmodule

`default_nettype wire
